### rtl/quadratic_probe_hash_table_core_macros.svh
// Assertion helpers for the hash table core.
`ifndef QUADRATIC_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication.
`define QPHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define QPHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/qpht_pkg.sv
`timescale 1ns / 1ps
package qpht_pkg;

  // Table depth; a power of two (home slot is the low key bits).
  localparam int TABLE_SIZE = 32;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int SLOT_W     = 5;
  localparam int KEY_W      = 31;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [63:0]      name_low;
    logic [63:0]      name_mid;
    logic [31:0]      name_high;
    logic [15:0]      year;
  } rec_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    rd;
    logic    step;
    logic    wr;
    logic    ld_res;
    status_t res_code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic func_search;
    logic slot_valid;
    logic key_match;
    logic last_probe;
  } sts_t;

  // (a + b) mod TABLE_SIZE for a, b < TABLE_SIZE
  function automatic idx_t add_mod(idx_t a, idx_t b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IDX_W+1)'(TABLE_SIZE)) begin
      sum = sum - (IDX_W+1)'(TABLE_SIZE);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(idx_t p);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, p};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

### rtl/qpht_req_if.sv
`timescale 1ns / 1ps
interface qpht_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [30:0] key;
  logic [63:0] name_low;
  logic [63:0] name_mid;
  logic [31:0] name_high;
  logic [15:0] year;

  modport source (output valid, func, key, name_low, name_mid, name_high, year,
                  input ready);
  modport sink   (input valid, func, key, name_low, name_mid, name_high, year,
                  output ready);
endinterface

### rtl/qpht_res_if.sv
`timescale 1ns / 1ps
interface qpht_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  slot;
  logic [30:0] found_key;
  logic [63:0] found_name_low;
  logic [63:0] found_name_mid;
  logic [31:0] found_name_high;
  logic [15:0] found_year;

  modport source (output valid, status, slot, found_key, found_name_low,
                  found_name_mid, found_name_high, found_year,
                  input ready);
  modport sink   (input valid, status, slot, found_key, found_name_low,
                  found_name_mid, found_name_high, found_year,
                  output ready);
endinterface

### rtl/qpht_ctrl.sv
`timescale 1ns / 1ps
module qpht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  qpht_pkg::sts_t    sts,
  output qpht_pkg::cmd_t    cmd
);

  qpht_pkg::state_t  state;
  qpht_pkg::state_t  state_next;
  logic              res_pending;
  logic              res_free;
  logic              finish;
  logic              advance;
  qpht_pkg::status_t code;

  assign res_free = !res_pending || res_ready;

  // probe outcome, valid in S_CHECK
  always_comb begin
    finish  = 1'b0;
    advance = 1'b0;
    code    = qpht_pkg::ST_NOT_FOUND;
    if (sts.func_search == qpht_pkg::FUNC_SEARCH) begin
      priority if (!sts.slot_valid) begin
        finish = 1'b1;
        code   = qpht_pkg::ST_NOT_FOUND;
      end else if (sts.key_match) begin
        finish = 1'b1;
        code   = qpht_pkg::ST_FOUND;
      end else if (sts.last_probe) begin
        finish = 1'b1;
        code   = qpht_pkg::ST_NOT_FOUND;
      end else begin
        advance = 1'b1;
      end
    end else begin
      priority if (!sts.slot_valid) begin
        finish = 1'b1;
        code   = qpht_pkg::ST_STORED;
      end else if (sts.last_probe) begin
        finish = 1'b1;
        code   = qpht_pkg::ST_FULL;
      end else begin
        advance = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qpht_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = qpht_pkg::S_READ;
        end
      end
      qpht_pkg::S_READ: begin
        state_next = qpht_pkg::S_CHECK;
      end
      qpht_pkg::S_CHECK: begin
        if (advance) begin
          state_next = qpht_pkg::S_READ;
        end else if (finish && res_free) begin
          state_next = qpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = qpht_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    cmd          = '0;
    cmd.res_code = code;
    unique case (state)
      qpht_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      qpht_pkg::S_READ: begin
        cmd.rd = 1'b1;
      end
      qpht_pkg::S_CHECK: begin
        cmd.step   = advance;
        cmd.ld_res = finish && res_free;
        cmd.wr     = finish && res_free && (code == qpht_pkg::ST_STORED);
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= qpht_pkg::S_IDLE;
      res_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ld_res) begin
        res_pending <= 1'b1;
      end else if (res_ready) begin
        res_pending <= 1'b0;
      end
    end
  end

  assign res_valid = res_pending;

endmodule

### rtl/qpht_dpath.sv
`timescale 1ns / 1ps
module qpht_dpath (
  input  logic                clk,
  input  logic                rst,
  input  qpht_pkg::cmd_t      cmd,
  output qpht_pkg::sts_t      sts,
  input  logic                func,
  input  logic [30:0]         key,
  input  logic [63:0]         name_low,
  input  logic [63:0]         name_mid,
  input  logic [31:0]         name_high,
  input  logic [15:0]         year,
  output logic [1:0]          status,
  output logic [4:0]          slot,
  output logic [30:0]         found_key,
  output logic [63:0]         found_name_low,
  output logic [63:0]         found_name_mid,
  output logic [31:0]         found_name_high,
  output logic [15:0]         found_year
);

  qpht_pkg::rec_t  mem [qpht_pkg::TABLE_SIZE];
  qpht_pkg::rec_t  rd_data;
  qpht_pkg::rec_t  req_rec;
  logic [qpht_pkg::TABLE_SIZE-1:0] valid_bits;

  logic            func_q;
  qpht_pkg::idx_t  p;
  qpht_pkg::idx_t  j;
  qpht_pkg::idx_t  sq;   // j*j mod size
  qpht_pkg::idx_t  odd;  // 2j+1 mod size

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q            <= func;
      req_rec.key       <= key;
      req_rec.name_low  <= name_low;
      req_rec.name_mid  <= name_mid;
      req_rec.name_high <= name_high;
      req_rec.year      <= year;
      p                 <= key[qpht_pkg::IDX_W-1:0];
      j                 <= '0;
      sq                <= '0;
      odd               <= qpht_pkg::idx_t'(1);
    end else if (cmd.step) begin
      p   <= qpht_pkg::add_mod(p, sq);
      j   <= j + qpht_pkg::idx_t'(1);
      sq  <= qpht_pkg::add_mod(sq, odd);
      odd <= qpht_pkg::add_mod(odd, qpht_pkg::idx_t'(2));
    end
  end

  // record store
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[p] <= req_rec;
    end
    if (cmd.rd) begin
      rd_data <= mem[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.wr) begin
      valid_bits[p] <= 1'b1;
    end
  end

  assign sts.func_search = func_q;
  assign sts.slot_valid  = valid_bits[p];
  assign sts.key_match   = (rd_data.key == req_rec.key);
  assign sts.last_probe  = (j == qpht_pkg::idx_t'(qpht_pkg::TABLE_SIZE - 1));

  // response register
  always_ff @(posedge clk) begin
    if (cmd.ld_res) begin
      status <= cmd.res_code;
      if (cmd.res_code == qpht_pkg::ST_STORED || cmd.res_code == qpht_pkg::ST_FOUND) begin
        slot <= qpht_pkg::to_slot(p);
      end else begin
        slot <= '0;
      end
      if (cmd.res_code == qpht_pkg::ST_FOUND) begin
        found_key       <= rd_data.key;
        found_name_low  <= rd_data.name_low;
        found_name_mid  <= rd_data.name_mid;
        found_name_high <= rd_data.name_high;
        found_year      <= rd_data.year;
      end else begin
        found_key       <= '0;
        found_name_low  <= '0;
        found_name_mid  <= '0;
        found_name_high <= '0;
        found_year      <= '0;
      end
    end
  end

endmodule

### rtl/quadratic_probe_hash_table_core.sv
// Each request probes 1..TABLE_SIZE slots; each probe is a registered record
//   read (S_READ) plus a check (S_CHECK), and a finishing check waits while the
//   output register is full. The next request is taken while the previous
//   response still waits in the output register.
// Reset (rst, synchronous, active high) clears the controller and all slot valid
//   bits at once; no clearing pass, the table is empty on the first cycle after.
`timescale 1ns / 1ps
`include "quadratic_probe_hash_table_core_macros.svh"
module quadratic_probe_hash_table_core (
  input  logic       clk,
  input  logic       rst,
  qpht_req_if.sink   req,
  qpht_res_if.source res
);

  // Controller sequences each request: S_IDLE takes it and latches the home
  // slot (low key bits), S_READ reads the slot record, S_CHECK looks at the
  // valid bit and, for a search, the key, then finishes, steps to the next
  // probe slot or waits while the response register is full. The probe offset
  // j*j is kept as a running sum of odd numbers; a step is three modular adds.
  qpht_pkg::cmd_t cmd;
  qpht_pkg::sts_t sts;

  qpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: request latch, probe arithmetic, record memory, valid bits and
  // the response register.
  qpht_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .func            (req.func),
    .key             (req.key),
    .name_low        (req.name_low),
    .name_mid        (req.name_mid),
    .name_high       (req.name_high),
    .year            (req.year),
    .status          (res.status),
    .slot            (res.slot),
    .found_key       (res.found_key),
    .found_name_low  (res.found_name_low),
    .found_name_mid  (res.found_name_mid),
    .found_name_high (res.found_name_high),
    .found_year      (res.found_year)
  );

  // Busy straight after taking a request.
  `QPHT_ASSERT_NEXT(a_busy_after_req, clk, rst, req.valid && req.ready, !req.ready, "request taken while busy")
  // Response register only reloaded once free.
  `QPHT_ASSERT_NOW(a_res_free, clk, rst, cmd.ld_res, !res.valid || res.ready, "response overwritten")
  // Writes only for an insert landing on an empty slot.
  `QPHT_ASSERT_NOW(a_wr_empty, clk, rst, cmd.wr, !sts.slot_valid && (sts.func_search == qpht_pkg::FUNC_INSERT), "write to occupied slot")
  // Never probe beyond the table size.
  `QPHT_ASSERT_NOW(a_probe_bound, clk, rst, cmd.step, !sts.last_probe, "probe count overrun")

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import qpht_pkg::*;

  localparam int N_RANDOM     = 600;
  // Slowest honest run: ~630 requests, each with a probe of the whole table
  // and the longest gap on either side, plus one long hold-off.
  // Taken several times over.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * (2 * TABLE_SIZE + 1) + 50;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  // One request as the sender offers it; search leaves the record fields
  // unused apart from the key.
  typedef struct packed {
    logic func;
    rec_t rec;
  } lookup_req_t;

  // One response; rec carries the found_ fields.
  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    rec_t                 rec;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qpht_req_if req ();
  qpht_res_if res ();

  quadratic_probe_hash_table_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  // Requests still to be offered, oldest first; the head is the one on the bus.
  lookup_req_t      pending_reqs[$];
  // Responses the table should still produce, in request order.
  lookup_res_t      expected_res[$];
  // Keys handed to insert so far, so that searches can aim at live entries.
  logic [KEY_W-1:0] inserted_keys[$];

  // Shadow of the table contents.
  logic model_valid [TABLE_SIZE];
  rec_t model_rec   [TABLE_SIZE];

  int   errors       = 0;
  int   results_seen = 0;
  int   cycle_count  = 0;
  logic req_fired    = 1'b0;

  int   tx_gap    = 0;
  int   tx_burst  = 0;
  int   rx_gap    = 0;
  int   rx_burst  = 0;
  int   hold_left = 0;
  logic held_once = 1'b0;

  always #2 clk = ~clk;

  // Idle length between requests: mostly none or a few cycles, now and then
  // a long one, and occasional runs with no idling at all.
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Quadratic probe over the shadow table. The step offset j*j is added to
  // the current slot, so offsets accumulate; at most TABLE_SIZE slots are
  // looked at. Insert takes the first free slot, search the first live slot
  // whose key matches and gives up at a free slot.
  function automatic lookup_res_t table_access(lookup_req_t rq);
    lookup_res_t r;
    int          p;
    int          j;
    logic        done;
    r.slot = '0;
    r.rec  = '0;
    if (rq.func == FUNC_INSERT) begin
      r.status = ST_FULL;
    end else begin
      r.status = ST_NOT_FOUND;
    end
    p    = int'(rq.rec.key % TABLE_SIZE);
    done = 1'b0;
    for (j = 0; j < TABLE_SIZE && !done; j++) begin
      if (rq.func == FUNC_INSERT) begin
        if (!model_valid[p]) begin
          model_valid[p] = 1'b1;
          model_rec[p]   = rq.rec;
          r.status       = ST_STORED;
          r.slot         = SLOT_W'(p);
          done           = 1'b1;
        end
      end else if (!model_valid[p]) begin
        done = 1'b1;
      end else if (model_rec[p].key == rq.rec.key) begin
        r.status = ST_FOUND;
        r.slot   = SLOT_W'(p);
        r.rec    = model_rec[p];
        done     = 1'b1;
      end
      if (!done) begin
        p = (p + (j * j) % TABLE_SIZE) % TABLE_SIZE;
      end
    end
    return r;
  endfunction

  task automatic queue_req(input logic func, input logic [KEY_W-1:0] key,
                           input logic [63:0] nl, input logic [63:0] nm,
                           input logic [31:0] nh, input logic [15:0] yr);
    lookup_req_t rq;
    rq.func          = func;
    rq.rec.key       = key;
    rq.rec.name_low  = nl;
    rq.rec.name_mid  = nm;
    rq.rec.name_high = nh;
    rq.rec.year      = yr;
    pending_reqs.push_back(rq);
    if (func == FUNC_INSERT) inserted_keys.push_back(key);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Request side, sampled at the rising edge. The shadow table is updated in
  // acceptance order, which is also the order the responses come back in.
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      expected_res.push_back(table_access(pending_reqs.pop_front()));
      req_fired = 1'b1;
    end
  end

  // Request driver, falling edge. A request on the bus stays put until it is
  // taken; valid is only written once per edge so back-to-back requests keep
  // it high.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!(req.valid && !req_fired)) begin
      req_fired = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req.valid     <= 1'b1;
        req.func      <= pending_reqs[0].func;
        req.key       <= pending_reqs[0].rec.key;
        req.name_low  <= pending_reqs[0].rec.name_low;
        req.name_mid  <= pending_reqs[0].rec.name_mid;
        req.name_high <= pending_reqs[0].rec.name_high;
        req.year      <= pending_reqs[0].rec.year;
        tx_gap = pick_gap(tx_burst);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Response side: every accepted response is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    lookup_res_t want;
    if (!rst && res.valid && res.ready) begin
      results_seen++;
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t ns: response with nothing pending, status %0d slot %0d",
                 $time, res.status, res.slot);
      end else begin
        want = expected_res.pop_front();
        check_field("status",          64'(want.status),        64'(res.status));
        check_field("slot",            64'(want.slot),          64'(res.slot));
        check_field("found_key",       64'(want.rec.key),       64'(res.found_key));
        check_field("found_name_low",  want.rec.name_low,       res.found_name_low);
        check_field("found_name_mid",  want.rec.name_mid,       res.found_name_mid);
        check_field("found_name_high", 64'(want.rec.name_high), 64'(res.found_name_high));
        check_field("found_year",      64'(want.rec.year),      64'(res.found_year));
      end
    end
  end

  // Receiver ready, falling edge. Once, part way through, it holds off for a
  // long stretch so the output register and the core both fill and the
  // request side backs up.
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else if (!held_once && results_seen >= HOLD_AFTER) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      res.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      rx_gap = pick_gap(rx_burst);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int               i;
    int               pick;
    logic [KEY_W-1:0] k;

    req.valid     = 1'b0;
    req.func      = FUNC_INSERT;
    req.key       = '0;
    req.name_low  = '0;
    req.name_mid  = '0;
    req.name_high = '0;
    req.year      = '0;
    res.ready     = 1'b0;
    for (i = 0; i < TABLE_SIZE; i++) model_valid[i] = 1'b0;

    // Directed part.
    // search on an empty table stops at the home slot
    queue_req(FUNC_SEARCH, '0, '0, '0, '0, '0);
    // extremes of key and record fields
    queue_req(FUNC_INSERT, '0, '0, '0, '0, '0);
    queue_req(FUNC_INSERT, KEY_MAX, '1, '1, '1, '1);
    // search ignores name and year
    queue_req(FUNC_SEARCH, '0, '1, '1, '1, '1);
    queue_req(FUNC_SEARCH, KEY_MAX, '0, '0, '0, '0);
    // duplicate key goes further down the path; search still returns the first
    queue_req(FUNC_INSERT, '0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
              32'h5a5a_a5a5, 16'd1999);
    queue_req(FUNC_SEARCH, '0, '0, '0, '0, '0);
    // same home as key 0 but absent: runs into a free slot
    queue_req(FUNC_SEARCH, KEY_W'(32), '0, '0, '0, '0);
    // pile keys onto one home until its whole probe path is taken; the last
    // one comes back as table full
    for (i = 1; i <= 20; i++) begin
      queue_req(FUNC_INSERT, KEY_W'(7 + 32 * i), {$urandom, $urandom},
                {$urandom, $urandom}, $urandom, 16'($urandom));
    end
    // absent key on that full path: gives up after TABLE_SIZE probes
    queue_req(FUNC_SEARCH, KEY_W'(7 + 32 * 999), '0, '0, '0, '0);
    // hit deep down the path
    queue_req(FUNC_SEARCH, KEY_W'(7 + 32 * 18), '0, '0, '0, '0);

    // Random part: mostly searches for keys already handed in, the rest
    // inserts and searches for arbitrary keys.
    for (i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      k    = KEY_W'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        k = KEY_W'($urandom_range(0, TABLE_SIZE - 1) + TABLE_SIZE * $urandom_range(0, 3));
      end
      if (pick < 35) begin
        queue_req(FUNC_INSERT, k, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, 16'($urandom));
      end else begin
        if (pick < 85) begin
          k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        end
        queue_req(FUNC_SEARCH, k, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, 16'($urandom));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_reqs.size() == 0);
    wait (expected_res.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
